[hdl/cscan_disk_track_scheduler_top_defines.svh]
// ----------------------------------------------------------------------------
// C-SCAN disk scheduler assertion macros
// Shared concurrent assertion forms, clocked on clock, reset disabled.
// ----------------------------------------------------------------------------
`ifndef CSCAN_DISK_TRACK_SCHEDULER_TOP_DEFINES_SVH
`define CSCAN_DISK_TRACK_SCHEDULER_TOP_DEFINES_SVH

// invariant checked at every edge outside reset
`define CSCAN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// condition now implies expectation in the next cycle
`define CSCAN_ASSERT_NEXT(label, cond, expected, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (expected)) else $error(msg);

`endif

[hdl/cscan_pkg.sv]
// ----------------------------------------------------------------------------
// C-SCAN disk scheduler package
// Widths, queue sizing, action codes and input saturation helpers.
// ----------------------------------------------------------------------------
package cscan_pkg;

   localparam int TRACK_W  = 16;
   localparam int CLIENT_W = 4;
   localparam int AGE_W    = 8;

   localparam int QUEUE_SLOTS = 16;
   localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
   localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);

   localparam longint unsigned TRACK_COUNT = 65536;
   localparam int              CLIENTS     = 16;

   localparam logic ACTION_REQUEST = 1'b0;
   localparam logic ACTION_RELEASE = 1'b1;

   function automatic logic [TRACK_W-1:0] sat_track(input logic [TRACK_W-1:0] t);
      if (64'(t) >= TRACK_COUNT) begin
         return TRACK_W'(TRACK_COUNT - 64'd1);
      end
      return t;
   endfunction

   function automatic logic [CLIENT_W-1:0] sat_client(input logic [CLIENT_W-1:0] c);
      if (32'(c) >= CLIENTS) begin
         return CLIENT_W'(CLIENTS - 1);
      end
      return c;
   endfunction

endpackage

[hdl/cscan_req_if.sv]
// ----------------------------------------------------------------------------
// C-SCAN request channel
// Valid/ready channel carrying one request or release transaction.
// ----------------------------------------------------------------------------
interface cscan_req_if
   import cscan_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                action;
   logic [TRACK_W-1:0]  track;
   logic [CLIENT_W-1:0] requester;

   modport source (output valid, output action, output track, output requester,
                   input ready);
   modport sink   (input valid, input action, input track, input requester,
                   output ready);
endinterface

[hdl/cscan_rsp_if.sv]
// ----------------------------------------------------------------------------
// C-SCAN response channel
// Valid/ready channel carrying one scheduling result transaction.
// ----------------------------------------------------------------------------
interface cscan_rsp_if
   import cscan_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                granted;
   logic [CLIENT_W-1:0] grant_requester;
   logic [TRACK_W-1:0]  grant_track;
   logic                queued;
   logic                rejected;
   logic                disk_busy;

   modport source (output valid, output granted, output grant_requester,
                   output grant_track, output queued, output rejected,
                   output disk_busy, input ready);
   modport sink   (input valid, input granted, input grant_requester,
                   input grant_track, input queued, input rejected,
                   input disk_busy, output ready);
endinterface

[hdl/cscan_disk_track_scheduler_top.sv]
// ----------------------------------------------------------------------------
// C-SCAN disk track scheduler
// Grants the disk arm to requesters in circular-scan order from a small queue.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  req_bus   in   action, track, requester
//  rsp_bus   out  granted, grant_requester, grant_track, queued, rejected,
//                 disk_busy
//
//  Request on an idle disk or a full queue: accept, then finish.
//  Other transactions: accept, a scan of all QUEUE_SLOTS slots, one slot per
//  cycle through a single track/age comparator, then finish.
//  Reset clears control, sweep counts and slot valid bits; slot contents stay.
//  A result waits in the response register; the next transaction is accepted
//  meanwhile, and finish holds until the response register is free.
// ----------------------------------------------------------------------------
`include "cscan_disk_track_scheduler_top_defines.svh"

module cscan_disk_track_scheduler_top
   import cscan_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   cscan_req_if.sink   req_bus,
   cscan_rsp_if.source rsp_bus
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                act_ff, act_in;
   logic [TRACK_W-1:0]  trk_ff, trk_in;
   logic [CLIENT_W-1:0] cli_ff, cli_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;

   logic                busy_ff, busy_in;
   logic [TRACK_W-1:0]  head_ff, head_in;
   logic                active_ff, active_in;
   logic [AGE_W-1:0]    arrival_ff, arrival_in;
   logic [CNT_W-1:0]    cnt_ff [2];
   logic [CNT_W-1:0]    cnt_in [2];

   logic [QUEUE_SLOTS-1:0] valid_ff, valid_in;
   logic                   sweep_ff  [QUEUE_SLOTS];
   logic [TRACK_W-1:0]     track_ff  [QUEUE_SLOTS];
   logic [CLIENT_W-1:0]    client_ff [QUEUE_SLOTS];
   logic [AGE_W-1:0]       age_ff    [QUEUE_SLOTS];

   logic                best_found_ff, best_found_in;
   logic [SLOT_W-1:0]   best_idx_ff, best_idx_in;
   logic [TRACK_W-1:0]  best_trk_ff, best_trk_in;
   logic [AGE_W-1:0]    best_dist_ff, best_dist_in;
   logic                free_found_ff, free_found_in;
   logic [SLOT_W-1:0]   free_idx_ff, free_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                granted_ff, granted_in;
   logic [CLIENT_W-1:0] g_req_ff, g_req_in;
   logic [TRACK_W-1:0]  g_trk_ff, g_trk_in;
   logic                queued_ff, queued_in;
   logic                rejected_ff, rejected_in;
   logic                disk_busy_ff, disk_busy_in;

   logic                slot_we;
   logic                slot_sweep_wr;

   logic                accept;
   logic                out_free;
   logic [CNT_W-1:0]    cnt_total;
   logic                queue_full;
   logic                cur_valid;
   logic [TRACK_W-1:0]  cur_trk;
   logic [AGE_W-1:0]    cur_dist;
   logic                cand;
   logic                better;
   logic                new_sweep;

   assign accept     = req_bus.valid && req_bus.ready;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign cnt_total  = CNT_W'(cnt_ff[0] + cnt_ff[1]);
   assign queue_full = (cnt_total == CNT_W'(QUEUE_SLOTS));

   assign cur_valid = valid_ff[idx_ff];
   assign cur_trk   = track_ff[idx_ff];
   assign cur_dist  = AGE_W'(arrival_ff - age_ff[idx_ff] - AGE_W'(1));
   assign cand      = (act_ff == ACTION_RELEASE) && cur_valid
                      && (sweep_ff[idx_ff] == active_ff);
   assign better    = !best_found_ff || (cur_trk < best_trk_ff)
                      || ((cur_trk == best_trk_ff) && (cur_dist > best_dist_ff));
   assign new_sweep = (trk_ff < head_ff) ? ~active_ff : active_ff;

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      trk_in        = trk_ff;
      cli_in        = cli_ff;
      idx_in        = idx_ff;
      busy_in       = busy_ff;
      head_in       = head_ff;
      active_in     = active_ff;
      arrival_in    = arrival_ff;
      cnt_in[0]     = cnt_ff[0];
      cnt_in[1]     = cnt_ff[1];
      valid_in      = valid_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_trk_in   = best_trk_ff;
      best_dist_in  = best_dist_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      granted_in    = granted_ff;
      g_req_in      = g_req_ff;
      g_trk_in      = g_trk_ff;
      queued_in     = queued_ff;
      rejected_in   = rejected_ff;
      disk_busy_in  = disk_busy_ff;
      slot_we       = 1'b0;
      slot_sweep_wr = new_sweep;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in        = req_bus.action;
               trk_in        = sat_track(req_bus.track);
               cli_in        = sat_client(req_bus.requester);
               idx_in        = '0;
               best_found_in = 1'b0;
               free_found_in = 1'b0;
               if (req_bus.action == ACTION_RELEASE) begin
                  if (cnt_ff[active_ff] == '0) begin
                     active_in = ~active_ff;
                  end
                  state_in = ST_SCAN;
               end else if (!busy_ff || queue_full) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cand && better) begin
               best_found_in = 1'b1;
               best_idx_in   = idx_ff;
               best_trk_in   = cur_trk;
               best_dist_in  = cur_dist;
            end
            if ((act_ff == ACTION_REQUEST) && !cur_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (idx_ff == SLOT_W'(QUEUE_SLOTS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = SLOT_W'(idx_ff + SLOT_W'(1));
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               granted_in   = 1'b0;
               g_req_in     = '0;
               g_trk_in     = '0;
               queued_in    = 1'b0;
               rejected_in  = 1'b0;
               if (act_ff == ACTION_REQUEST) begin
                  if (!busy_ff) begin
                     busy_in    = 1'b1;
                     head_in    = trk_ff;
                     granted_in = 1'b1;
                     g_req_in   = cli_ff;
                     g_trk_in   = trk_ff;
                  end else if (queue_full) begin
                     rejected_in = 1'b1;
                  end else begin
                     slot_we                = 1'b1;
                     valid_in[free_idx_ff]  = 1'b1;
                     cnt_in[new_sweep]      = CNT_W'(cnt_ff[new_sweep] + CNT_W'(1));
                     arrival_in             = AGE_W'(arrival_ff + AGE_W'(1));
                     queued_in              = 1'b1;
                  end
               end else if (best_found_ff) begin
                  valid_in[best_idx_ff] = 1'b0;
                  cnt_in[active_ff]     = CNT_W'(cnt_ff[active_ff] - CNT_W'(1));
                  head_in               = best_trk_ff;
                  busy_in               = 1'b1;
                  granted_in            = 1'b1;
                  g_req_in              = client_ff[best_idx_ff];
                  g_trk_in              = best_trk_ff;
               end else begin
                  busy_in = 1'b0;
               end
               disk_busy_in = busy_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         head_ff      <= '0;
         active_ff    <= 1'b0;
         arrival_ff   <= '0;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         head_ff      <= head_in;
         active_ff    <= active_in;
         arrival_ff   <= arrival_in;
         cnt_ff[0]    <= cnt_in[0];
         cnt_ff[1]    <= cnt_in[1];
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      trk_ff        <= trk_in;
      cli_ff        <= cli_in;
      idx_ff        <= idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_trk_ff   <= best_trk_in;
      best_dist_ff  <= best_dist_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      granted_ff    <= granted_in;
      g_req_ff      <= g_req_in;
      g_trk_ff      <= g_trk_in;
      queued_ff     <= queued_in;
      rejected_ff   <= rejected_in;
      disk_busy_ff  <= disk_busy_in;
      if (slot_we) begin
         sweep_ff[free_idx_ff]  <= slot_sweep_wr;
         track_ff[free_idx_ff]  <= trk_ff;
         client_ff[free_idx_ff] <= cli_ff;
         age_ff[free_idx_ff]    <= arrival_ff;
      end
   end

   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.granted         = granted_ff;
   assign rsp_bus.grant_requester = g_req_ff;
   assign rsp_bus.grant_track     = g_trk_ff;
   assign rsp_bus.queued          = queued_ff;
   assign rsp_bus.rejected        = rejected_ff;
   assign rsp_bus.disk_busy       = disk_busy_ff;

   `CSCAN_ASSERT(a_idle_queue_empty, (busy_ff || (cnt_total == '0)), "idle disk with queued entries")
   `CSCAN_ASSERT(a_queue_bound, (cnt_total <= CNT_W'(QUEUE_SLOTS)), "queue count exceeds slots")
   `CSCAN_ASSERT_NEXT(a_finish_responds, ((state_ff == ST_FINISH) && out_free), rsp_valid_ff, "finish without response")
   `CSCAN_ASSERT_NEXT(a_accept_leaves_idle, accept, (state_ff != ST_IDLE), "accept did not start work")

endmodule

[dv/cscan_disk_track_scheduler_top_tb.sv]
// ----------------------------------------------------------------------------
// C-SCAN disk track scheduler testbench
// A short directed table and then randomized request/release traffic go
// through the valid/ready request channel. A local circular-scan model predicts
// each response transaction, and the responses are compared field by field in
// order. Both channels idle at random, and the response side holds off once
// for a long stretch so that the scheduler backs up into its input.
// ----------------------------------------------------------------------------
module cscan_disk_track_scheduler_top_tb
   import cscan_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1950;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 4 * (QUEUE_SLOTS + 2);
   localparam int HOLD_CYCLES  = 2500;
   localparam int HOLD_AFTER   = 400;

   typedef struct packed {
      logic                granted;
      logic [CLIENT_W-1:0] grant_requester;
      logic [TRACK_W-1:0]  grant_track;
      logic                queued;
      logic                rejected;
      logic                disk_busy;
   } sched_outcome_type;

   typedef struct {
      logic                action;
      logic [TRACK_W-1:0]  track;
      logic [CLIENT_W-1:0] requester;
      bit                  fixed;
      sched_outcome_type   outcome;
   } disk_op_type;

   localparam sched_outcome_type NO_OUTCOME = '0;

   logic clock = 1'b0;
   logic reset;

   cscan_req_if req_bus ();
   cscan_rsp_if rsp_bus ();

   cscan_disk_track_scheduler_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scheduler model state
   logic [TRACK_W-1:0]  arm_track = '0;
   bit                  arm_busy = 1'b0;
   bit                  cur_lap = 1'b0;
   bit                  waiting[QUEUE_SLOTS];
   bit                  wait_lap[QUEUE_SLOTS];
   logic [TRACK_W-1:0]  wait_track[QUEUE_SLOTS];
   logic [CLIENT_W-1:0] wait_client[QUEUE_SLOTS];
   logic [AGE_W-1:0]    wait_stamp[QUEUE_SLOTS];
   logic [AGE_W-1:0]    next_stamp = '0;

   disk_op_type       disk_ops_q[$];
   sched_outcome_type pending_outcomes_q[$];

   int send_idx = 0;
   int send_gap = 0;
   int send_burst = 0;
   int recv_stall = 0;
   int recv_run = 0;
   int recv_burst = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int outcomes_seen = 0;
   int mismatches = 0;
   int cycle_count = 0;

   function automatic sched_outcome_type schedule_step(input logic act,
                                                       input logic [TRACK_W-1:0] trk_in,
                                                       input logic [CLIENT_W-1:0] who_in);
      sched_outcome_type   res;
      logic [TRACK_W-1:0]  trk;
      logic [CLIENT_W-1:0] who;
      logic [AGE_W-1:0]    dist_i;
      logic [AGE_W-1:0]    dist_b;
      int                  pick;
      bit                  lap_has;
      res = NO_OUTCOME;
      trk = (64'(trk_in) >= TRACK_COUNT) ? TRACK_W'(TRACK_COUNT - 64'd1) : trk_in;
      who = (32'(who_in) >= CLIENTS) ? CLIENT_W'(CLIENTS - 1) : who_in;
      pick = -1;
      if (act == ACTION_REQUEST) begin
         if (!arm_busy) begin
            arm_busy = 1'b1;
            arm_track = trk;
            res.granted = 1'b1;
            res.grant_requester = who;
            res.grant_track = trk;
         end else begin
            for (int i = 0; i < QUEUE_SLOTS; i++) begin
               if (!waiting[i] && pick < 0) begin
                  pick = i;
               end
            end
            if (pick < 0) begin
               res.rejected = 1'b1;
            end else begin
               waiting[pick] = 1'b1;
               wait_lap[pick] = (trk < arm_track) ? ~cur_lap : cur_lap;
               wait_track[pick] = trk;
               wait_client[pick] = who;
               wait_stamp[pick] = next_stamp;
               next_stamp = next_stamp + 1'b1;
               res.queued = 1'b1;
            end
         end
      end else begin
         lap_has = 1'b0;
         for (int i = 0; i < QUEUE_SLOTS; i++) begin
            if (waiting[i] && wait_lap[i] == cur_lap) begin
               lap_has = 1'b1;
            end
         end
         if (!lap_has) begin
            cur_lap = ~cur_lap;
         end
         for (int i = 0; i < QUEUE_SLOTS; i++) begin
            if (waiting[i] && wait_lap[i] == cur_lap) begin
               if (pick < 0) begin
                  pick = i;
               end else begin
                  dist_i = next_stamp - wait_stamp[i] - 1'b1;
                  dist_b = next_stamp - wait_stamp[pick] - 1'b1;
                  if (wait_track[i] < wait_track[pick] ||
                      (wait_track[i] == wait_track[pick] && dist_i > dist_b)) begin
                     pick = i;
                  end
               end
            end
         end
         if (pick >= 0) begin
            waiting[pick] = 1'b0;
            arm_track = wait_track[pick];
            arm_busy = 1'b1;
            res.granted = 1'b1;
            res.grant_requester = wait_client[pick];
            res.grant_track = wait_track[pick];
         end else begin
            arm_busy = 1'b0;
         end
      end
      res.disk_busy = arm_busy;
      return res;
   endfunction

   function automatic void add_op(input logic act, input logic [TRACK_W-1:0] trk,
                                  input logic [CLIENT_W-1:0] who, input bit fixed,
                                  input sched_outcome_type outcome);
      disk_op_type op;
      op.action = act;
      op.track = trk;
      op.requester = who;
      op.fixed = fixed;
      op.outcome = outcome;
      disk_ops_q.push_back(op);
   endfunction

   function automatic int gap_len(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst = $urandom_range(30, 120);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [TRACK_W-1:0] pick_track();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return '0;
         1: return '1;
         2, 3, 4: return TRACK_W'($urandom_range(0, 63));
         5: return TRACK_W'(32768 + $urandom_range(0, 15) - 8);
         default: return TRACK_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch: %s on response %0d: got %0h, expected %0h",
               what, outcomes_seen, got, want);
   endtask

   initial begin
      int mode;
      int phase_len;
      int req_pct;
      int made;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = ACTION_REQUEST;
      req_bus.track = '0;
      req_bus.requester = '0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
         waiting[i] = 1'b0;
         wait_lap[i] = 1'b0;
         wait_track[i] = '0;
         wait_client[i] = '0;
         wait_stamp[i] = '0;
      end

      // release on idle, extremes, sweep swap, going idle
      add_op(ACTION_RELEASE, 16'h1234, 4'd5, 1, NO_OUTCOME);
      add_op(ACTION_REQUEST, 16'hFFFF, 4'd15, 1,
             sched_outcome_type'{1'b1, 4'd15, 16'hFFFF, 1'b0, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'h0000, 4'd0, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'hFFFF, 4'd3, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_RELEASE, 16'h0, 4'd0, 0, NO_OUTCOME);
      add_op(ACTION_RELEASE, 16'h0, 4'd0, 0, NO_OUTCOME);
      add_op(ACTION_RELEASE, 16'hFFFF, 4'd15, 1, NO_OUTCOME);
      add_op(ACTION_REQUEST, 16'd100, 4'd1, 1,
             sched_outcome_type'{1'b1, 4'd1, 16'd100, 1'b0, 1'b0, 1'b1});
      // fill every slot, equal tracks in arrival order, then overflow
      add_op(ACTION_REQUEST, 16'd200, 4'd2, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd200, 4'd4, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd200, 4'd6, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd50, 4'd7, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd50, 4'd8, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd0, 4'd9, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'hFFFF, 4'd10, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd100, 4'd11, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd99, 4'd12, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd101, 4'd13, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd300, 4'd14, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd300, 4'd5, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd7, 4'd0, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'hFFFF, 4'd15, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd1000, 4'd3, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd200, 4'd9, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b1, 1'b0, 1'b1});
      add_op(ACTION_REQUEST, 16'd500, 4'd15, 1,
             sched_outcome_type'{1'b0, 4'd0, 16'h0, 1'b0, 1'b1, 1'b1});
      for (int i = 0; i < 3; i++) begin
         add_op(ACTION_RELEASE, 16'h0, 4'd0, 0, NO_OUTCOME);
      end

      // random phases: filling, draining and mixed traffic
      made = 0;
      while (made < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         phase_len = $urandom_range(10, 60);
         req_pct = (mode == 0) ? 80 : (mode == 1) ? 25 : 55;
         for (int i = 0; i < phase_len && made < RANDOM_ITEMS; i++) begin
            add_op(($urandom_range(0, 99) < req_pct) ? ACTION_REQUEST : ACTION_RELEASE,
                   pick_track(), CLIENT_W'($urandom_range(0, 15)), 0, NO_OUTCOME);
            made++;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (send_idx < disk_ops_q.size()) @(posedge clock);
      while (pending_outcomes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("cscan_disk_track_scheduler_top_tb: done, clean");
      end else begin
         $display("cscan_disk_track_scheduler_top_tb: done, errors");
      end
      $finish;
   end

   // request driver and model update on each accepted transaction
   always @(posedge clock) begin : req_drive
      logic              took;
      int                next_idx;
      sched_outcome_type outcome;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         took = req_bus.valid && req_bus.ready;
         if (took) begin
            outcome = schedule_step(req_bus.action, req_bus.track, req_bus.requester);
            if (disk_ops_q[send_idx].fixed) begin
               outcome = disk_ops_q[send_idx].outcome;
            end
            pending_outcomes_q.push_back(outcome);
         end
         next_idx = send_idx + (took ? 1 : 0);
         if (req_bus.valid && !took) begin
            // hold the offered transaction
         end else if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (next_idx < disk_ops_q.size()) begin
            req_bus.valid <= 1'b1;
            req_bus.action <= disk_ops_q[next_idx].action;
            req_bus.track <= disk_ops_q[next_idx].track;
            req_bus.requester <= disk_ops_q[next_idx].requester;
            send_gap <= gap_len(send_burst);
         end else begin
            req_bus.valid <= 1'b0;
         end
         send_idx <= next_idx;
      end
   end

   // one long response hold-off
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && outcomes_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall <= 0;
         recv_run <= 0;
      end else if (recv_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         recv_stall <= recv_stall - 1;
      end else begin
         rsp_bus.ready <= (hold_left == 0);
         if (recv_run > 0) begin
            recv_run <= recv_run - 1;
         end else begin
            recv_run <= $urandom_range(0, 30);
            recv_stall <= gap_len(recv_burst);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      sched_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes_q.size() == 0) begin
            report_mismatch("transaction with nothing pending", 32'(rsp_bus.granted), 0);
         end else begin
            want = pending_outcomes_q.pop_front();
            if (rsp_bus.granted !== want.granted)
               report_mismatch("granted", 32'(rsp_bus.granted), 32'(want.granted));
            if (rsp_bus.grant_requester !== want.grant_requester)
               report_mismatch("grant_requester", 32'(rsp_bus.grant_requester),
                               32'(want.grant_requester));
            if (rsp_bus.grant_track !== want.grant_track)
               report_mismatch("grant_track", 32'(rsp_bus.grant_track),
                               32'(want.grant_track));
            if (rsp_bus.queued !== want.queued)
               report_mismatch("queued", 32'(rsp_bus.queued), 32'(want.queued));
            if (rsp_bus.rejected !== want.rejected)
               report_mismatch("rejected", 32'(rsp_bus.rejected), 32'(want.rejected));
            if (rsp_bus.disk_busy !== want.disk_busy)
               report_mismatch("disk_busy", 32'(rsp_bus.disk_busy), 32'(want.disk_busy));
         end
         outcomes_seen <= outcomes_seen + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cscan_disk_track_scheduler_top_tb: done, errors");
         $finish;
      end
   end

endmodule

[cscan_disk_track_scheduler_top.f]
+incdir+hdl
hdl/cscan_pkg.sv
hdl/cscan_req_if.sv
hdl/cscan_rsp_if.sv
hdl/cscan_disk_track_scheduler_top.sv
dv/cscan_disk_track_scheduler_top_tb.sv
